### hdl/mexp_pkg.sv
// ----------------------------------------------------------------------------
// mexp_pkg
// Widths, constants and unit request/response types for the modular
// exponentiation block
// ----------------------------------------------------------------------------
package mexp_pkg;

  localparam int BASE_W = 63;
  localparam int EXP_W  = 32;
  localparam int RES_W  = 30;
  localparam int MUL_W  = 32;
  localparam int PROD_W = 2 * MUL_W;
  localparam int SUM_W  = 61;
  localparam int Q_LSB  = 29;

  // prime modulus, floor(2^61 / prime) and 2^32 mod prime
  localparam logic [MUL_W-1:0] MODULUS    = 32'd1000000007;
  localparam logic [MUL_W-1:0] BARRETT_MU = 32'd2305842993;
  localparam logic [MUL_W-1:0] TWO32_MOD  = 32'd294967268;

  typedef logic [RES_W-1:0] res_t;
  typedef logic [MUL_W-1:0] word_t;

  // unit computes (a * b + lo) mod prime
  typedef struct packed {
    logic  start;
    word_t a;
    word_t b;
    word_t lo;
  } mm_req_t;

  typedef struct packed {
    logic done;
    res_t value;
  } mm_rsp_t;

endpackage

### hdl/mexp_if.sv
// ----------------------------------------------------------------------------
// mexp_if
// Valid/ready channels for base/exponent requests and residue results
// ----------------------------------------------------------------------------
interface mexp_in_if import mexp_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [BASE_W-1:0]       base;
  logic signed [EXP_W-1:0] exponent;

  modport source (output valid, output base, output exponent, input ready);
  modport sink   (input valid, input base, input exponent, output ready);
endinterface

interface mexp_out_if import mexp_pkg::*; ();
  logic       valid;
  logic       ready;
  res_t       residue;

  modport source (output valid, output residue, input ready);
  modport sink   (input valid, input residue, output ready);
endinterface

### hdl/mexp_mul.sv
// ----------------------------------------------------------------------------
// mexp_mul
// Registered 32 x 32 unsigned multiplier, shared by every product of the
// modular multiply
// ----------------------------------------------------------------------------
module mexp_mul import mexp_pkg::*; (
  input  logic              clk,
  input  word_t             op_a,
  input  word_t             op_b,
  output logic [PROD_W-1:0] prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(op_a) * PROD_W'(op_b);
  end

endmodule

### hdl/mexp_modmul.sv
// ----------------------------------------------------------------------------
// mexp_modmul
// Modular multiply-add unit: (a * b + lo) mod prime by Barrett reduction,
// all products on one shared multiplier
// ----------------------------------------------------------------------------
module mexp_modmul import mexp_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  mm_req_t req,
  output mm_rsp_t rsp
);

  localparam logic [2:0] U_IDLE = 3'd0;
  localparam logic [2:0] U_SUM  = 3'd1;
  localparam logic [2:0] U_QUO  = 3'd2;
  localparam logic [2:0] U_QP   = 3'd3;
  localparam logic [2:0] U_SUB  = 3'd4;
  localparam logic [2:0] U_FIX  = 3'd5;

  logic [2:0]       state_r, state_nxt;
  word_t            lo_r, lo_nxt;
  logic [SUM_W-1:0] v_r, v_nxt;
  word_t            r_r, r_nxt;
  word_t            op_a, op_b;
  logic [PROD_W-1:0] prod;
  logic             r_big;

  mexp_mul u_mul (
    .clk    (clk),
    .op_a   (op_a),
    .op_b   (op_b),
    .prod_r (prod)
  );

  assign r_big = (r_r >= MODULUS);

  always_comb begin
    state_nxt = state_r;
    lo_nxt    = lo_r;
    v_nxt     = v_r;
    r_nxt     = r_r;
    op_a      = req.a;
    op_b      = req.b;
    case (state_r)
      U_IDLE: begin
        if (req.start) begin
          lo_nxt    = req.lo;
          state_nxt = U_SUM;
        end
      end
      U_SUM: begin
        v_nxt     = prod[SUM_W-1:0] + SUM_W'(lo_r);
        state_nxt = U_QUO;
      end
      U_QUO: begin
        // quotient estimate from the top bits of v
        op_a      = v_r[SUM_W-1:Q_LSB];
        op_b      = BARRETT_MU;
        state_nxt = U_QP;
      end
      U_QP: begin
        op_a      = prod[PROD_W-1:MUL_W];
        op_b      = MODULUS;
        state_nxt = U_SUB;
      end
      U_SUB: begin
        // remainder is below three times the prime, so the low word is enough
        r_nxt     = v_r[MUL_W-1:0] - prod[MUL_W-1:0];
        state_nxt = U_FIX;
      end
      U_FIX: begin
        if (r_big) begin
          r_nxt = r_r - MODULUS;
        end else begin
          state_nxt = U_IDLE;
        end
      end
      default: begin
        state_nxt = U_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= U_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    lo_r <= lo_nxt;
    v_r  <= v_nxt;
    r_r  <= r_nxt;
  end

  assign rsp.done  = (state_r == U_FIX) && !r_big;
  assign rsp.value = r_r[RES_W-1:0];

endmodule

### hdl/modular_exponentiation.sv
// ----------------------------------------------------------------------------
// modular_exponentiation
// Base to a signed exponent modulo 1000000007, right-to-left
// square-and-multiply over one shared modular multiply unit
// ----------------------------------------------------------------------------
//  channel   dir  payload                              handshake
//  in_chan   in   base[62:0], exponent[31:0] signed    valid / ready
//  out_chan  out  residue[29:0]                        valid / ready
//
//  each modular multiply runs as a sequence of steps on the shared multiplier
//  (product, add, quotient, quotient times prime, subtract, fix-ups until below the prime)
//  an item costs one base reduction, one squaring per exponent bit below
//  the top one and one multiply per set bit (at most 62 operations); a zero
//  or negative exponent gives a residue of 1 with no unit operation
//  in_chan.ready is high only between items; a finished result waits in the
//  output register, and the next request is taken while it waits
//  reset is synchronous, active low, and clears the sequencer and out valid
module modular_exponentiation import mexp_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  mexp_in_if.sink       in_chan,
  mexp_out_if.source    out_chan
);

  localparam logic [2:0] T_IDLE = 3'd0;
  localparam logic [2:0] T_BASE = 3'd1;
  localparam logic [2:0] T_MULR = 3'd2;
  localparam logic [2:0] T_SQR  = 3'd3;
  localparam logic [2:0] T_DONE = 3'd4;

  logic [2:0]        state_r, state_nxt;
  logic              start_r, start_nxt;
  logic [BASE_W-1:0] base_r, base_nxt;
  logic [EXP_W-2:0]  e_r, e_nxt;
  res_t              x_r, x_nxt;
  res_t              acc_r, acc_nxt;
  logic              out_valid_r, out_valid_nxt;
  res_t              out_residue_r, out_residue_nxt;
  mm_req_t           mm_req;
  mm_rsp_t           mm_rsp;
  logic              in_fire;

  mexp_modmul u_modmul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mm_req),
    .rsp   (mm_rsp)
  );

  assign in_chan.ready    = (state_r == T_IDLE);
  assign in_fire          = in_chan.valid && in_chan.ready;
  assign out_chan.valid   = out_valid_r;
  assign out_chan.residue = out_residue_r;

  // unit operands follow the step under way
  always_comb begin
    mm_req.start = start_r;
    mm_req.a     = {2'b00, x_r};
    mm_req.b     = {2'b00, x_r};
    mm_req.lo    = '0;
    case (state_r)
      T_BASE: begin
        // fold the high word: hi * (2^32 mod prime) + lo
        mm_req.a  = {1'b0, base_r[BASE_W-1:MUL_W]};
        mm_req.b  = TWO32_MOD;
        mm_req.lo = base_r[MUL_W-1:0];
      end
      T_MULR: begin
        mm_req.b = {2'b00, acc_r};
      end
      default: begin
        mm_req.b = {2'b00, x_r};
      end
    endcase
  end

  always_comb begin
    state_nxt       = state_r;
    start_nxt       = 1'b0;
    base_nxt        = base_r;
    e_nxt           = e_r;
    x_nxt           = x_r;
    acc_nxt         = acc_r;
    out_valid_nxt   = out_valid_r && !out_chan.ready;
    out_residue_nxt = out_residue_r;
    case (state_r)
      T_IDLE: begin
        if (in_fire) begin
          base_nxt = in_chan.base;
          e_nxt    = in_chan.exponent[EXP_W-2:0];
          acc_nxt  = RES_W'(1);
          if (in_chan.exponent[EXP_W-1] || (in_chan.exponent == '0)) begin
            state_nxt = T_DONE;
          end else begin
            state_nxt = T_BASE;
            start_nxt = 1'b1;
          end
        end
      end
      T_BASE: begin
        if (mm_rsp.done) begin
          x_nxt     = mm_rsp.value;
          start_nxt = 1'b1;
          state_nxt = e_r[0] ? T_MULR : T_SQR;
        end
      end
      T_MULR: begin
        if (mm_rsp.done) begin
          acc_nxt = mm_rsp.value;
          // last set bit: the remaining squaring would not change the result
          if (e_r[EXP_W-2:1] == '0) begin
            state_nxt = T_DONE;
          end else begin
            start_nxt = 1'b1;
            state_nxt = T_SQR;
          end
        end
      end
      T_SQR: begin
        if (mm_rsp.done) begin
          x_nxt     = mm_rsp.value;
          e_nxt     = e_r >> 1;
          start_nxt = 1'b1;
          state_nxt = e_r[1] ? T_MULR : T_SQR;
        end
      end
      T_DONE: begin
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt   = 1'b1;
          out_residue_nxt = acc_r;
          state_nxt       = T_IDLE;
        end
      end
      default: begin
        state_nxt = T_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= T_IDLE;
      start_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      start_r     <= start_nxt;
      out_valid_r <= out_valid_nxt;
    end
    base_r        <= base_nxt;
    e_r           <= e_nxt;
    x_r           <= x_nxt;
    acc_r         <= acc_nxt;
    out_residue_r <= out_residue_nxt;
  end

  // a finished result never coincides with a new unit request
  a_no_start_on_done: assert property (@(posedge clk) disable iff (!rst_n)
    mm_rsp.done |-> !mm_req.start)
    else $error("unit request issued while a response was pending");

  // results are fully reduced
  a_residue_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_residue_r < MODULUS[RES_W-1:0]))
    else $error("residue not below the modulus");

  // squaring and multiplying only while exponent bits remain
  a_exp_live: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == T_MULR || state_r == T_SQR) |-> (e_r != '0))
    else $error("exponent step with no exponent bits left");

endmodule
